/* sv/depq_pkg.sv */
`default_nettype none
package depq_pkg;
  localparam int DEPTH_DEF = 64;
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_POP_MAX = 2'd1;
  localparam logic [1:0] OP_POP_MIN = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic               full_drop;
    logic signed [31:0] largest;
    logic signed [31:0] smallest;
    logic [6:0]         live_count;
    logic               is_empty;
  } out_item_t;
endpackage
`default_nettype wire

/* sv/depq_ram.sv */
`default_nettype none
module depq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/double_ended_priority_queue.sv */
// Sorted array in one RAM, ascending from slot base_r (circular); pops only move a pointer.
// Steps per request: accept in ST_IDLE; an insert that fits then walks down from the top in
// ST_RD and ST_CMP, shifting larger entries up, and places the value; every request then reads
// min and max (ST_ENDS, ST_ENDS2) and emits in ST_DONE. A new request is taken only in ST_IDLE.
// A result held by out_stall keeps the block in ST_DONE, so it delays the next request as well.
// Reset empties the queue at once; RAM contents need no clearing.
`default_nettype none
module double_ended_priority_queue #(
  parameter int DEPTH = depq_pkg::DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire depq_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output depq_pkg::out_item_t      out_data
);
  import depq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;  // read slot below idx_r
  localparam logic [2:0] ST_CMP   = 3'd2;  // data back: shift up or place
  localparam logic [2:0] ST_ENDS  = 3'd3;  // read min
  localparam logic [2:0] ST_ENDS2 = 3'd4;  // min back, read max
  localparam logic [2:0] ST_DONE  = 3'd5;  // max back, emit

  logic [2:0]    st_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] base_r;
  logic [CW-1:0] idx_r;     // logical position being examined
  logic signed [31:0] val_r, min_r;
  logic          ok_r, drop_r;
  logic          out_free;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  // logical position to physical slot, modulo DEPTH
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [CW-1:0] p);
    logic [CW:0] s;
    s = {1'b0, CW'(b)} + {1'b0, p};
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  depq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_stall = (st_r != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    we    = 1'b0;
    waddr = phys(base_r, idx_r);
    wdata = rdata;
    raddr = phys(base_r, idx_r - CW'(1));
    unique case (st_r)
      ST_CMP: begin
        we = 1'b1;
        if (idx_r != '0 && $signed(rdata) > val_r) begin
          waddr = phys(base_r, idx_r);
          wdata = rdata;
        end else begin
          waddr = phys(base_r, idx_r);
          wdata = val_r;
        end
      end
      ST_ENDS:  raddr = base_r;
      ST_ENDS2: raddr = phys(base_r, cnt_r - CW'(1));
      // keep max on the read port while the result waits
      ST_DONE:  raddr = phys(base_r, cnt_r - CW'(1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      cnt_r     <= '0;
      base_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (st_r == ST_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (in_valid && !in_stall) begin
          val_r  <= in_data.value;
          ok_r   <= 1'b0;
          drop_r <= 1'b0;
          st_r   <= ST_ENDS;
          case (in_data.func)
            OP_INSERT: begin
              if (cnt_r == FULL) drop_r <= 1'b1;
              else begin
                ok_r  <= 1'b1;
                idx_r <= cnt_r;
                st_r  <= (cnt_r == '0) ? ST_CMP : ST_RD;
              end
            end
            OP_POP_MAX: if (cnt_r != '0) begin
              ok_r  <= 1'b1;
              cnt_r <= cnt_r - CW'(1);
            end
            OP_POP_MIN: if (cnt_r != '0) begin
              ok_r   <= 1'b1;
              cnt_r  <= cnt_r - CW'(1);
              base_r <= phys(base_r, CW'(1));
            end
            default: ;
          endcase
        end
        ST_RD: st_r <= ST_CMP;
        ST_CMP: begin
          if (idx_r != '0 && $signed(rdata) > val_r) begin
            idx_r <= idx_r - CW'(1);
            st_r  <= (idx_r == CW'(1)) ? ST_CMP : ST_RD;
          end else begin
            cnt_r <= cnt_r + CW'(1);
            st_r  <= ST_ENDS;
          end
        end
        ST_ENDS: st_r <= ST_ENDS2;
        ST_ENDS2: begin
          min_r <= rdata;
          st_r  <= ST_DONE;
        end
        ST_DONE: if (out_free) begin
          out_data.ok         <= ok_r;
          out_data.full_drop  <= drop_r;
          out_data.largest    <= (cnt_r == '0) ? '0 : $signed(rdata);
          out_data.smallest   <= (cnt_r == '0) ? '0 : min_r;
          out_data.live_count <= 7'(cnt_r);
          out_data.is_empty   <= (cnt_r == '0);
          st_r                <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
